### design/rsa_pkg.sv
package rsa_pkg;

  // Geometry
  localparam int SLOT_COUNT = 1024;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int NUM_WORDS  = (SLOT_COUNT + WORD_W - 1) / WORD_W;
  localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int FLAT_W     = WADDR_W + BIT_W;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int FREE_W     = $clog2(SLOT_COUNT + 1);

  // Field widths
  localparam int CNT_W    = 8;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 12;
  localparam int STATUS_W = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_INC   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_INVALID      = 3'd1,
    ST_ALREADY_FREE = 3'd2,
    ST_NONE_FREE    = 3'd3,
    ST_DISABLED     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ
  } state_t;

  // Lowest set bit of a bitmap word
  function automatic logic [BIT_W-1:0] first_bit(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

  // Lowest word flagged as holding a free slot
  function automatic logic [WADDR_W-1:0] first_word(input logic [NUM_WORDS-1:0] s);
    logic [WADDR_W-1:0] pos;
    pos = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (s[i]) pos = WADDR_W'(i);
    end
    return pos;
  endfunction

  // Free map of a word after reset: ones for slots that exist
  function automatic logic [WORD_W-1:0] init_word(input logic [WADDR_W-1:0] w);
    logic [WORD_W-1:0] m;
    for (int j = 0; j < WORD_W; j++) begin
      m[j] = ((int'(w) * WORD_W + j) < SLOT_COUNT);
    end
    return m;
  endfunction

endpackage

### design/rsa_if.sv
interface rsa_req_if import rsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, kind, slot, input ready);
  modport sink   (input valid, kind, slot, output ready);
endinterface

interface rsa_rsp_if import rsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   granted_slot;
  logic [STATUS_W-1:0] status;
  logic                became_free;
  logic [SLOT_W-1:0]   slots_left;

  modport source (output valid, granted_slot, status, became_free, slots_left, input ready);
  modport sink   (input valid, granted_slot, status, became_free, slots_left, output ready);
endinterface

interface rsa_cfg_if import rsa_pkg::*; ();
  logic valid;
  logic ready;
  logic swap_enabled;

  modport source (output valid, swap_enabled, input ready);
  modport sink   (input valid, swap_enabled, output ready);
endinterface

### design/refcounted_slot_allocator_core.sv
// Reference-counted first-fit slot allocator.
// Channels: in_ch carries requests (kind, 1-based slot), out_ch returns one
// result per request, cfg_ch writes swap_enabled (always ready). All use
// valid/ready; a transfer happens on a clock edge with both high.
// On the accept edge, reads of the count RAM and the free-map RAM are
// launched; the write-back state that follows modifies and writes back and
// loads the output register. One request is in flight at a time, so no new
// request is taken until the last one has been written back.
// Allocate finds its slot through a summary register (one bit per 32-slot
// word that still has a free slot) and a 32-bit encoder on the word read back.
// Reset (rst_n low, synchronous) starts a clearing pass over all SLOT_COUNT
// slots (1024 here) that zeroes every count and rebuilds the free map; in_ch
// is not ready until it ends. cfg_ch writes are taken during the pass.
// If out_ch stalls with a result pending, the request in flight holds in the
// write-back state with its read data steady until the output frees up.
module refcounted_slot_allocator_core import rsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rsa_cfg_if.sink    cfg_ch,
  rsa_req_if.sink    in_ch,
  rsa_rsp_if.source  out_ch
);

  // State and sequencing
  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  logic                swap_en_r;
  logic [FREE_W-1:0]   free_r, free_nxt;
  logic [NUM_WORDS-1:0] summary_r, summary_nxt;

  // Request held across the RAM read
  kind_t               kind_r;
  logic                slot_ok_r;
  logic [FLAT_W-1:0]   idx_r;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]   granted_r, granted_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                became_r, became_nxt;
  logic [SLOT_W-1:0]   slots_left_r, slots_left_nxt;

  // Request decode
  logic                accept;
  logic                slot_ok;
  logic [FLAT_W-1:0]   req_idx;
  logic [WADDR_W-1:0]  alloc_word;
  logic [FLAT_W-1:0]   latch_idx;

  // Write-back datapath
  logic                fin;
  logic [CNT_W-1:0]    cnt_rd;
  logic [WORD_W-1:0]   map_rd;
  logic [BIT_W-1:0]    bpos;
  logic [WADDR_W-1:0]  wsel;
  logic [FLAT_W-1:0]   tgt;
  logic [WORD_W-1:0]   bit_mask;
  logic [WORD_W-1:0]   map_clr, map_set;

  // RAM ports
  logic                cnt_we, map_we;
  logic [IDX_W-1:0]    cnt_waddr;
  logic [CNT_W-1:0]    cnt_wdata;
  logic [WADDR_W-1:0]  map_waddr;
  logic [WORD_W-1:0]   map_wdata;
  logic [WADDR_W-1:0]  map_raddr;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;

  assign slot_ok    = (in_ch.slot != '0) && (in_ch.slot <= SLOT_W'(SLOT_COUNT));
  assign req_idx    = FLAT_W'(in_ch.slot - SLOT_W'(1));
  assign alloc_word = first_word(summary_r);
  assign latch_idx  = (kind_t'(in_ch.kind) == KIND_ALLOC) ? {alloc_word, {BIT_W{1'b0}}}
                                                           : req_idx;
  assign map_raddr  = latch_idx[FLAT_W-1:BIT_W];

  rsa_ram #(.DATA_W(CNT_W), .DEPTH(SLOT_COUNT)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (accept),
    .raddr (req_idx[IDX_W-1:0]),
    .rdata (cnt_rd)
  );

  rsa_ram #(.DATA_W(WORD_W), .DEPTH(NUM_WORDS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (accept),
    .raddr (map_raddr),
    .rdata (map_rd)
  );

  // Write-back addressing: allocate picks the bit, free/inc use the slot's bit
  assign wsel     = idx_r[FLAT_W-1:BIT_W];
  assign bpos     = (kind_r == KIND_ALLOC) ? first_bit(map_rd) : idx_r[BIT_W-1:0];
  assign tgt      = {wsel, bpos};
  assign bit_mask = WORD_W'(1) << bpos;
  assign map_clr  = map_rd & ~bit_mask;
  assign map_set  = map_rd | bit_mask;
  assign fin      = (state_r == S_READ) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    free_nxt       = free_r;
    summary_nxt    = summary_r;
    cnt_we         = 1'b0;
    cnt_waddr      = tgt[IDX_W-1:0];
    cnt_wdata      = cnt_rd;
    map_we         = 1'b0;
    map_waddr      = wsel;
    map_wdata      = map_rd;
    granted_nxt    = '0;
    status_nxt     = ST_OK;
    became_nxt     = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    slots_left_nxt = slots_left_r;

    unique case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        map_we    = (int'(clr_r) < NUM_WORDS);
        map_waddr = WADDR_W'(clr_r);
        map_wdata = init_word(WADDR_W'(clr_r));
        clr_nxt   = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(SLOT_COUNT - 1)) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (accept) state_nxt = S_READ;
      end

      S_READ: begin
        if (!swap_en_r) begin
          status_nxt = ST_DISABLED;
        end else begin
          case (kind_r)
            KIND_ALLOC: begin
              if (free_r == '0) begin
                status_nxt = ST_NONE_FREE;
              end else begin
                cnt_we      = 1'b1;
                cnt_wdata   = CNT_W'(1);
                map_we      = 1'b1;
                map_wdata   = map_clr;
                summary_nxt[wsel] = (map_clr != '0);
                free_nxt    = free_r - FREE_W'(1);
                granted_nxt = SLOT_W'(tgt) + SLOT_W'(1);
              end
            end
            KIND_FREE: begin
              if (!slot_ok_r) begin
                status_nxt = ST_INVALID;
              end else if (cnt_rd == '0) begin
                status_nxt = ST_ALREADY_FREE;
              end else begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_rd - CNT_W'(1);
                if (cnt_rd == CNT_W'(1)) begin
                  map_we            = 1'b1;
                  map_wdata         = map_set;
                  summary_nxt[wsel] = 1'b1;
                  free_nxt          = free_r + FREE_W'(1);
                  became_nxt        = 1'b1;
                end
              end
            end
            KIND_INC: begin
              if (!slot_ok_r) begin
                status_nxt = ST_INVALID;
              end else begin
                cnt_we    = 1'b1;
                cnt_wdata = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + CNT_W'(1);
                if (cnt_rd == '0) begin
                  map_we            = 1'b1;
                  map_wdata         = map_clr;
                  summary_nxt[wsel] = (map_clr != '0);
                  free_nxt          = free_r - FREE_W'(1);
                end
              end
            end
            default: status_nxt = ST_OK;
          endcase
        end
        slots_left_nxt = SLOT_W'(free_nxt);

        // hold everything while the output register is still occupied
        if (fin) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cnt_we         = 1'b0;
          map_we         = 1'b0;
          free_nxt       = free_r;
          summary_nxt    = summary_r;
          granted_nxt    = granted_r;
          status_nxt     = status_r;
          became_nxt     = became_r;
          slots_left_nxt = slots_left_r;
        end
      end

      default: state_nxt = S_CLEAR;
    endcase

    if (state_r != S_READ) begin
      granted_nxt    = granted_r;
      status_nxt     = status_r;
      became_nxt     = became_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      swap_en_r   <= 1'b1;
      free_r      <= FREE_W'(SLOT_COUNT);
      summary_r   <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_r      <= free_nxt;
      summary_r   <= summary_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) swap_en_r <= cfg_ch.swap_enabled;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= kind_t'(in_ch.kind);
      slot_ok_r <= slot_ok;
      idx_r     <= latch_idx;
    end
    granted_r    <= granted_nxt;
    status_r     <= status_nxt;
    became_r     <= became_nxt;
    slots_left_r <= slots_left_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted_slot = granted_r;
  assign out_ch.status       = status_r;
  assign out_ch.became_free  = became_r;
  assign out_ch.slots_left   = slots_left_r;

  // Summary map and free count must agree on "nothing free"
  a_summary_free: assert property (@(posedge clk) disable iff (!rst_n)
    (summary_r == '0) == (free_r == '0))
    else $error("summary map disagrees with free count");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FREE_W'(SLOT_COUNT))
    else $error("free count above slot count");

  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_READ))
    else $error("accepted request did not enter write-back");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (granted_r != '0)) |-> (status_r == ST_OK && !became_r))
    else $error("grant with bad status");

  a_became_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && became_r) |-> (status_r == ST_OK && slots_left_r != '0))
    else $error("became_free with inconsistent result");

endmodule

### design/rsa_ram.sv
module rsa_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### bench/slot_alloc_monitor.sv
`timescale 1ns / 100ps

module slot_alloc_monitor import rsa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rsa_req_if   req,
  rsa_rsp_if   rsp,
  rsa_cfg_if   cfg,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   none_free_seen,
  output int   disabled_seen,
  output int   released_seen
);

  typedef struct packed {
    logic [SLOT_W-1:0] granted;
    status_t           status;
    logic              became_free;
    logic [SLOT_W-1:0] slots_left;
  } slot_result_t;

  logic [CNT_W-1:0]  use_count [SLOT_COUNT];
  logic [SLOT_W-1:0] free_left;
  logic              enabled;
  slot_result_t      owed [$];

  // Applies one request to the shadow table and returns what the block must answer.
  function automatic slot_result_t apply_request(input kind_t k, input logic [SLOT_W-1:0] s);
    slot_result_t r;
    bit           in_range;
    int           idx;
    r.granted     = '0;
    r.status      = ST_OK;
    r.became_free = 1'b0;
    in_range      = (s != '0) && (int'(s) <= SLOT_COUNT);
    idx           = int'(s) - 1;
    if (!enabled) begin
      r.status = ST_DISABLED;
    end else begin
      case (k)
        KIND_ALLOC: begin
          r.status = ST_NONE_FREE;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (use_count[i] == '0) begin
              use_count[i] = 8'd1;
              free_left    = free_left - SLOT_W'(1);
              r.granted    = SLOT_W'(i + 1);
              r.status     = ST_OK;
              break;
            end
          end
        end
        KIND_FREE: begin
          if (!in_range) begin
            r.status = ST_INVALID;
          end else if (use_count[idx] == '0) begin
            r.status = ST_ALREADY_FREE;
          end else begin
            use_count[idx] = use_count[idx] - CNT_W'(1);
            if (use_count[idx] == '0) begin
              free_left     = free_left + SLOT_W'(1);
              r.became_free = 1'b1;
            end
          end
        end
        KIND_INC: begin
          if (!in_range) begin
            r.status = ST_INVALID;
          end else begin
            if (use_count[idx] == '0) free_left = free_left - SLOT_W'(1);
            if (use_count[idx] != COUNT_MAX) use_count[idx] = use_count[idx] + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
    r.slots_left = free_left;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    slot_result_t want;
    if (!rst_n) begin
      foreach (use_count[i]) use_count[i] = '0;
      free_left      = SLOT_W'(SLOT_COUNT);
      enabled        = 1'b1;
      owed.delete();
      fail_count     = 0;
      results_seen   = 0;
      none_free_seen = 0;
      disabled_seen  = 0;
      released_seen  = 0;
    end else begin
      // results first: the one leaving now belongs to an earlier request
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (owed.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no request pending: granted=%0d st=%0d freed=%0b free=%0d",
                     $realtime, rsp.granted_slot, rsp.status, rsp.became_free, rsp.slots_left);
        end else begin
          want = owed.pop_front();
          if (rsp.granted_slot !== want.granted || rsp.status !== want.status ||
              rsp.became_free !== want.became_free || rsp.slots_left !== want.slots_left) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch exp granted=%0d st=%0d freed=%0b free=%0d,",
                        " got %0d %0d %0b %0d"},
                       $realtime, want.granted, want.status, want.became_free, want.slots_left,
                       rsp.granted_slot, rsp.status, rsp.became_free, rsp.slots_left);
          end
        end
      end
      if (cfg.valid && cfg.ready) enabled = cfg.swap_enabled;
      if (req.valid && req.ready) begin
        want = apply_request(kind_t'(req.kind), req.slot);
        if (want.status == ST_NONE_FREE) none_free_seen++;
        if (want.status == ST_DISABLED) disabled_seen++;
        if (want.became_free) released_seen++;
        owed.push_back(want);
      end
    end
    pending = owed.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rsa_pkg::*;

  localparam int PERIOD         = 10;
  localparam int LONG_HOLD      = 300;   // result side held off this long, block backs up
  localparam int WATCHDOG_LIMIT = 6000;  // clearing pass plus long hold, several times over
  localparam int TAIL_CYCLES    = 8;     // margin after the last request

  logic clk = 1'b0;
  logic rst_n;

  always #(PERIOD / 2) clk = ~clk;

  rsa_req_if in_ch ();
  rsa_rsp_if out_ch ();
  rsa_cfg_if cfg_ch ();

  refcounted_slot_allocator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int fail_count, pending, results_seen, none_free_seen, disabled_seen, released_seen;

  slot_alloc_monitor ledger (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (in_ch),
    .rsp            (out_ch),
    .cfg            (cfg_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .none_free_seen (none_free_seen),
    .disabled_seen  (disabled_seen),
    .released_seen  (released_seen)
  );

  int requests_sent = 0;
  int cfg_writes    = 0;
  int hold_asks     = 0;   // bumped by stimulus, served by the result-side process
  bit quiet         = 1'b0; // final stretch: no idling on either side

  // ---------------------------------------------------------------------------
  // Watchdog: any stretch with no handshake on any channel beyond the limit
  // means the block hung.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: mostly ready, random stall bursts, plus the long hold-off
  // when stimulus asks for one. Hold length counted here, not by stimulus.
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int holds_done;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_asks) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All called at a rising edge and return at one.
  // ---------------------------------------------------------------------------

  // Offer one request, wait for it to be taken, maybe idle a burst after.
  task automatic issue(input kind_t k, input logic [SLOT_W-1:0] s);
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.slot  <= s;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every outstanding result has come back.
  // Pending is sampled on the falling edge, clear of the monitor's update.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.swap_enabled <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  // Mostly slots in the busy low region so frees and increments land on
  // live slots; some anywhere in range; the rest zero or past the top.
  function automatic logic [SLOT_W-1:0] pick_slot(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return SLOT_W'($urandom_range(1, span));
    if (r < 88) return SLOT_W'($urandom_range(1, SLOT_COUNT));
    if (r < 94) return '0;
    return SLOT_W'($urandom_range(SLOT_COUNT + 1, 4095));
  endfunction

  function automatic kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return KIND_ALLOC;
    if (r < 70) return KIND_FREE;
    if (r < 97) return KIND_INC;
    return KIND_NONE;
  endfunction

  task automatic random_run(input int n, input int span);
    repeat (n) issue(pick_kind(), pick_slot(span));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [SLOT_W-1:0] hot;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_ALLOC;
    in_ch.slot          = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.swap_enabled = 1'b1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // register write lands during the clearing pass; first request waits it out
    write_enable(1'b1);

    // --- directed: fresh table ---
    issue(KIND_ALLOC, 12'd4095);        // slot field ignored, grants 1
    issue(KIND_ALLOC, '0);              // grants 2
    issue(KIND_INC,   12'd1);           // count 2
    issue(KIND_FREE,  12'd1);           // count 1
    issue(KIND_FREE,  12'd1);           // count 0, slot released
    issue(KIND_FREE,  12'd1);           // already free
    issue(KIND_FREE,  '0);              // slot zero rejected
    issue(KIND_INC,   '0);
    issue(KIND_FREE,  SLOT_W'(SLOT_COUNT + 1)); // just past the top
    issue(KIND_INC,   12'd4095);
    issue(KIND_INC,   SLOT_W'(SLOT_COUNT)); // increment on a free slot claims it
    issue(KIND_FREE,  SLOT_W'(SLOT_COUNT));
    issue(KIND_FREE,  12'd2);
    issue(KIND_NONE,  12'd4095);        // unused kind: no effect
    issue(KIND_NONE,  '0);
    issue(KIND_ALLOC, 12'd2048);        // lowest free again: 1
    issue(KIND_INC,   12'd1);
    issue(KIND_FREE,  12'd1);
    drain();

    // --- random mix, long result-side hold partway ---
    random_run(60, 48);
    hold_asks++;
    random_run(60, 48);

    // --- drive one slot's count into saturation, then back off ---
    hot = SLOT_W'($urandom_range(1, 32));
    repeat (258) issue(KIND_INC, hot);
    repeat (3) issue(KIND_FREE, hot);
    drain();

    // --- disabled: nothing may change ---
    write_enable(1'b0);
    random_run(40, 64);
    drain();
    write_enable(1'b1);

    // --- fill the table past exhaustion ---
    repeat (SLOT_COUNT + 6) issue(KIND_ALLOC, SLOT_W'($urandom_range(0, 4095)));
    drain();

    // --- churn on a full table: scattered frees, first-fit across words ---
    random_run(70, SLOT_COUNT);
    hold_asks++;
    random_run(70, SLOT_COUNT);
    drain();
    write_enable(1'b0);
    random_run(5, SLOT_COUNT);
    drain();
    write_enable(1'b1);

    // --- back-to-back, no idling anywhere ---
    quiet = 1'b1;
    random_run(40, SLOT_COUNT);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d results, %0d enable writes, incl. exhaustion and saturation",
             requests_sent, results_seen, cfg_writes);
    $display("%0d allocations found nothing free, %0d requests while disabled, %0d slots released",
             none_free_seen, disabled_seen, released_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
